// ----- rtl/core/tpar_pkg.sv -----
// Shared types and constants for the period-averaging tachometer.
package tpar_pkg;

  // Width of the capture timer and of the per-capture period.
  localparam int unsigned TIME_W = 16;

  // Width of the running period sum and of the divider datapath.
  localparam int unsigned SUM_W = 32;

  // Width of the per-channel capture counter.
  localparam int unsigned COUNT_W = 16;

  // One quotient bit is produced per divider step.
  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned STEP_W = $clog2(DIV_STEPS);

  // Configuration register indexes (byte address divided by four).
  localparam logic REG_TICKS_PER_MINUTE = 1'b0;
  localparam logic REG_EDGES_PER_REV = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [31:0] TICKS_PER_MINUTE_RESET = 32'd60000000;
  localparam logic [7:0] EDGES_PER_REV_RESET = 8'd28;

  // Capture request.
  typedef struct packed {
    logic              channel;
    logic [TIME_W-1:0] capture_time;
  } cap_req_t;

  // Speed result request.
  typedef struct packed {
    logic              out_channel;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] average_period;
    logic [31:0]       speed_rpm;
    logic              zero_average;
  } res_req_t;

endpackage

// ----- rtl/core/tachometer_period_average_rpm_top.sv -----
// Period-averaging tachometer: per-channel period statistics and rpm computation.

// Each capture request carries a channel and a free-running 16-bit timer value.
// The block forms the period as the wrapping difference from the previous capture
// on that channel. It keeps a 32-bit period sum and a 16-bit capture count per
// channel. The first capture, and the first after the count wraps, reports the raw
// period as its average and does not add it to the sum. Later captures add the
// period and report sum / count, where count is the value before the increment.
// Speed is floor(ticks_per_minute / (average * edges_per_rev)). It is 0 when that
// product is zero, and zero_average flags a zero average. One restoring divider,
// one quotient bit per cycle, serves both divisions. A capture whose average is
// the raw period skips the first division. When the product is zero the speed
// division is skipped as well. The next capture is taken only once the block
// is back in idle. The result waits in an output register, so a stalled result
// holds back only the next capture's finishing step. cap_stall is high whenever
// a capture is being worked on. Configuration is written through the APB-style
// port at byte address 0 (ticks_per_minute) and byte address 4 (edges_per_rev).
// Write it only while the block is idle.
module tachometer_period_average_rpm_top #(
  parameter int unsigned NUM_CHANNELS = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cap_valid,
  output logic                cap_stall,
  input  tpar_pkg::cap_req_t  cap,
  output logic                res_valid,
  input  logic                res_stall,
  output tpar_pkg::res_req_t  res,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_AVG,
    ST_MUL,
    ST_DIV_SPD,
    ST_FINISH
  } state_t;

  state_t state;

  // Configuration registers.
  logic [31:0] ticks_per_minute;
  logic [7:0]  edges_per_rev;

  // Per-channel measurement state.
  logic [tpar_pkg::TIME_W-1:0]  last_capture  [NUM_CHANNELS];
  logic [tpar_pkg::SUM_W-1:0]   period_sum    [NUM_CHANNELS];
  logic [tpar_pkg::COUNT_W-1:0] capture_count [NUM_CHANNELS];

  // Fields of the request being worked on.
  logic                        cur_channel;
  logic [tpar_pkg::TIME_W-1:0] cur_period;
  logic [tpar_pkg::TIME_W-1:0] cur_avg;

  // Shared restoring divider: quo shifts the dividend out and the quotient in.
  logic [tpar_pkg::SUM_W-1:0]  quo;
  logic [tpar_pkg::SUM_W-1:0]  rem;
  logic [tpar_pkg::SUM_W-1:0]  dvsr;
  logic [tpar_pkg::STEP_W-1:0] step;

  logic [tpar_pkg::SUM_W:0]    rem_shift;
  logic [tpar_pkg::SUM_W+1:0]  rem_diff;
  logic                        rem_ge;
  logic [tpar_pkg::SUM_W-1:0]  rem_next;
  logic [tpar_pkg::SUM_W-1:0]  quo_next;
  logic                        div_last;

  // Capture-side combinational values.
  logic                         cap_accept;
  logic [CH_W-1:0]              ch_sel;
  logic [tpar_pkg::TIME_W-1:0]  new_period;
  logic [tpar_pkg::SUM_W-1:0]   sum_next;
  logic [tpar_pkg::COUNT_W-1:0] count_sel;

  logic [23:0] divisor_prod;
  logic        cfg_write;

  assign cap_accept = cap_valid && !cap_stall;
  assign cap_stall  = (state != ST_IDLE);

  assign ch_sel     = (NUM_CHANNELS > 1) ? CH_W'(cap.channel) : '0;
  assign new_period = cap.capture_time - last_capture[ch_sel];
  assign count_sel  = capture_count[ch_sel];
  assign sum_next   = period_sum[ch_sel] + tpar_pkg::SUM_W'(new_period);

  assign rem_shift = {rem, quo[tpar_pkg::SUM_W-1]};
  assign rem_diff  = {1'b0, rem_shift} - {2'b00, dvsr};
  assign rem_ge    = !rem_diff[tpar_pkg::SUM_W+1];
  assign rem_next  = rem_ge ? rem_diff[tpar_pkg::SUM_W-1:0] : rem_shift[tpar_pkg::SUM_W-1:0];
  assign quo_next  = {quo[tpar_pkg::SUM_W-2:0], rem_ge};
  assign div_last  = (step == tpar_pkg::STEP_W'(tpar_pkg::DIV_STEPS - 1));

  assign divisor_prod = cur_avg * edges_per_rev;

  // The APB-style configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      tpar_pkg::REG_TICKS_PER_MINUTE: prdata = ticks_per_minute;
      tpar_pkg::REG_EDGES_PER_REV:    prdata = {24'd0, edges_per_rev};
      default:                        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_minute <= tpar_pkg::TICKS_PER_MINUTE_RESET;
      edges_per_rev    <= tpar_pkg::EDGES_PER_REV_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        tpar_pkg::REG_TICKS_PER_MINUTE: ticks_per_minute <= pwdata;
        tpar_pkg::REG_EDGES_PER_REV:    edges_per_rev    <= pwdata[7:0];
        default:                        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      step      <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        last_capture[i]  <= '0;
        period_sum[i]    <= '0;
        capture_count[i] <= '0;
      end
    end else begin
      // The finishing step reloads the output register itself, so the
      // hand-off only clears it in the other states.
      if (res_valid && !res_stall && (state != ST_FINISH)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cap_accept) begin
            cur_channel           <= ch_sel[0];
            cur_period            <= new_period;
            last_capture[ch_sel]  <= cap.capture_time;
            capture_count[ch_sel] <= count_sel + 1'b1;
            if (count_sel == '0) begin
              // First capture since reset or count wrap: raw period is the average.
              cur_avg <= new_period;
              state   <= ST_MUL;
            end else begin
              period_sum[ch_sel] <= sum_next;
              quo                <= sum_next;
              rem                <= '0;
              dvsr               <= tpar_pkg::SUM_W'(count_sel);
              step               <= '0;
              state              <= ST_DIV_AVG;
            end
          end
        end
        ST_DIV_AVG: begin
          quo  <= quo_next;
          rem  <= rem_next;
          step <= step + 1'b1;
          if (div_last) begin
            cur_avg <= quo_next[tpar_pkg::TIME_W-1:0];
            state   <= ST_MUL;
          end
        end
        ST_MUL: begin
          rem  <= '0;
          dvsr <= tpar_pkg::SUM_W'(divisor_prod);
          step <= '0;
          if (divisor_prod == '0) begin
            // Zero divisor forces the speed to zero.
            quo   <= '0;
            state <= ST_FINISH;
          end else begin
            quo   <= ticks_per_minute;
            state <= ST_DIV_SPD;
          end
        end
        ST_DIV_SPD: begin
          quo  <= quo_next;
          rem  <= rem_next;
          step <= step + 1'b1;
          if (div_last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!res_valid || !res_stall) begin
            res_valid          <= 1'b1;
            res.out_channel    <= cur_channel;
            res.period         <= cur_period;
            res.average_period <= cur_avg;
            res.speed_rpm      <= quo;
            res.zero_average   <= (cur_avg == '0);
            state              <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // An accepted capture keeps the input stalled while it is worked on.
  assert property (@(posedge clk) disable iff (rst) cap_accept |=> cap_stall)
    else $error("capture input not stalled after a capture was accepted");

  // A zero average always reports zero speed.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.zero_average) |-> (res.speed_rpm == '0))
    else $error("nonzero speed reported with a zero average");

  // The speed division never runs with a zero divisor.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_SPD) |-> (dvsr != '0))
    else $error("speed division started with a zero divisor");

  // A new result appears only as the finishing step of a capture.
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == ST_FINISH))
    else $error("result produced outside the finishing step");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the period-averaging tachometer.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Register byte addresses: the register index sits above the two byte-offset bits.
  localparam logic [2:0] ADDR_TICKS = {tpar_pkg::REG_TICKS_PER_MINUTE, 2'b00};
  localparam logic [2:0] ADDR_PULSES = {tpar_pkg::REG_EDGES_PER_REV, 2'b00};

  // Run length: the slowest legal run is roughly 1400 captures times
  // (divider work + the longest result stall + the longest idle gap),
  // plus one long receiver hold. The limit is several times that.
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned LONG_HOLD = 800;
  localparam int unsigned RANDOM_PHASES = 7;
  localparam int unsigned CAPTURES_PER_PHASE = 200;
  localparam int unsigned DRAIN_CYCLES = 80;

  // Scoreboard. It keeps its own copy of the per-channel statistics and of
  // the two rate registers, predicts one speed result per accepted capture,
  // and compares results in order against those predictions.
  class speed_scoreboard;
    logic [tpar_pkg::TIME_W-1:0]  last_time [2];
    logic [tpar_pkg::SUM_W-1:0]   period_total [2];
    logic [tpar_pkg::COUNT_W-1:0] capture_total [2];
    logic [31:0]                  ticks_per_min;
    logic [7:0]                   edges_per_rev;
    tpar_pkg::res_req_t           expected_speeds [$];
    int unsigned                  failures;

    function new();
      for (int i = 0; i < 2; i++) begin
        last_time[i] = '0;
        period_total[i] = '0;
        capture_total[i] = '0;
      end
      ticks_per_min = tpar_pkg::TICKS_PER_MINUTE_RESET;
      edges_per_rev = tpar_pkg::EDGES_PER_REV_RESET;
      failures = 0;
    endfunction

    function void set_rates(logic [31:0] ticks, logic [7:0] pulses);
      ticks_per_min = ticks;
      edges_per_rev = pulses;
    endfunction

    function int unsigned outstanding();
      return expected_speeds.size();
    endfunction

    function void flag(string what);
      failures++;
      if (failures <= 10) begin
        $display("[%0t] ERROR: %s", $realtime, what);
      end
    endfunction

    // Works out the result that an accepted capture must produce.
    function void note_capture(tpar_pkg::cap_req_t c);
      logic                        ch;
      logic [tpar_pkg::TIME_W-1:0] per;
      logic [tpar_pkg::TIME_W-1:0] avg;
      logic [63:0]                 divisor;
      tpar_pkg::res_req_t          want;
      ch = c.channel;
      per = c.capture_time - last_time[ch];
      last_time[ch] = c.capture_time;
      // A first capture, or the first after the count wraps, reports the raw
      // period and leaves the sum alone.
      if (capture_total[ch] == '0) begin
        avg = per;
      end else begin
        period_total[ch] = period_total[ch] + tpar_pkg::SUM_W'(per);
        avg = tpar_pkg::TIME_W'(period_total[ch] / tpar_pkg::SUM_W'(capture_total[ch]));
      end
      capture_total[ch] = capture_total[ch] + 1'b1;
      divisor = 64'(avg) * 64'(edges_per_rev);
      want.out_channel = ch;
      want.period = per;
      want.average_period = avg;
      want.speed_rpm = (divisor != 0) ? 32'(64'(ticks_per_min) / divisor) : 32'd0;
      want.zero_average = (avg == '0);
      expected_speeds.push_back(want);
    endfunction

    // Compares one accepted result with the oldest prediction.
    function void check_speed(tpar_pkg::res_req_t got);
      tpar_pkg::res_req_t want;
      if (expected_speeds.size() == 0) begin
        flag($sformatf("speed result with no capture pending: ch=%0d period=%0d",
                       got.out_channel, got.period));
        return;
      end
      want = expected_speeds.pop_front();
      if (got.out_channel !== want.out_channel || got.period !== want.period ||
          got.average_period !== want.average_period ||
          got.speed_rpm !== want.speed_rpm || got.zero_average !== want.zero_average) begin
        flag($sformatf({"speed result mismatch: got ch=%0d period=%0d avg=%0d rpm=%0d ",
                        "zero=%0d, expected ch=%0d period=%0d avg=%0d rpm=%0d zero=%0d"},
                       got.out_channel, got.period, got.average_period, got.speed_rpm,
                       got.zero_average, want.out_channel, want.period,
                       want.average_period, want.speed_rpm, want.zero_average));
      end
    endfunction
  endclass

  // Clock, reset and all block inputs start at known values.
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cap_valid = 1'b0;
  logic               cap_stall;
  tpar_pkg::cap_req_t cap = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  tpar_pkg::res_req_t res;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  speed_scoreboard speeds = new();

  // Sender state: the timer value last used on each channel, and whether
  // idle gaps are inserted between capture requests in the current phase.
  logic [tpar_pkg::TIME_W-1:0] stim_time [2] = '{default: '0};
  bit                          gaps_on = 1'b0;

  // The main sequence bumps this to ask the receiver for one long hold.
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned stall_left = 0;
  int unsigned run_left = 0;
  int unsigned cycle_count = 0;

  tachometer_period_average_rpm_top dut (
    .clk       (clk),
    .rst       (rst),
    .cap_valid (cap_valid),
    .cap_stall (cap_stall),
    .cap       (cap),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a hung block or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver. Values read right after the clock edge are the ones the block
  // saw at that edge, so a result is taken when valid was high and our stall
  // was low. The stall pattern alternates between quiet runs and bursts of
  // mostly short, occasionally long stalls. A hold request from the main
  // sequence forces one long stall counted here.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      speeds.check_speed(res);
    end
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      stall_left = LONG_HOLD;
      run_left = 0;
    end
    if (stall_left > 0) begin
      res_stall <= 1'b1;
      stall_left--;
    end else if (run_left > 0) begin
      res_stall <= 1'b0;
      run_left--;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 150)
                                               : $urandom_range(1, 4);
      res_stall <= 1'b1;
      stall_left--;
    end else begin
      run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 400)
                                             : $urandom_range(0, 20);
      res_stall <= 1'b0;
    end
  end

  function automatic tpar_pkg::cap_req_t cap_of(logic ch, logic [tpar_pkg::TIME_W-1:0] t);
    tpar_pkg::cap_req_t c;
    c.channel = ch;
    c.capture_time = t;
    return c;
  endfunction

  // Idle gap before a request: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 200);
  endfunction

  // Random capture. Timer steps are mostly small or moderate, like a motor
  // running at a steady speed, with repeated timestamps, full-range steps
  // that wrap the timer, and jumps to an arbitrary timer value mixed in.
  function automatic tpar_pkg::cap_req_t next_capture();
    tpar_pkg::cap_req_t c;
    int unsigned        r;
    c.channel = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 8) begin
      stim_time[c.channel] = stim_time[c.channel];
    end else if (r < 45) begin
      stim_time[c.channel] = stim_time[c.channel] +
                             tpar_pkg::TIME_W'($urandom_range(1, 64));
    end else if (r < 75) begin
      stim_time[c.channel] = stim_time[c.channel] +
                             tpar_pkg::TIME_W'($urandom_range(65, 4000));
    end else if (r < 92) begin
      stim_time[c.channel] = stim_time[c.channel] + tpar_pkg::TIME_W'($urandom);
    end else begin
      stim_time[c.channel] = tpar_pkg::TIME_W'($urandom);
    end
    c.capture_time = stim_time[c.channel];
    return c;
  endfunction

  // Offers one capture request and holds it until the block takes it. When
  // no gap is wanted the valid stays high and only the payload moves on.
  task automatic send_capture(input tpar_pkg::cap_req_t c);
    int unsigned gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      cap_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cap <= c;
    cap_valid <= 1'b1;
    do @(posedge clk); while (!(cap_valid && !cap_stall));
    speeds.note_capture(c);
  endtask

  // Stops offering captures until every predicted result has come back.
  task automatic wait_idle();
    cap_valid <= 1'b0;
    while (speeds.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write: a setup phase, then an access phase that completes at
  // the first edge with pready high.
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Register read: the data is taken at the edge that completes the access.
  task automatic reg_read(input logic [2:0] addr, output logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes both rate registers, reads them back, and updates the scoreboard.
  // Only called while the block is idle.
  task automatic set_rates(input logic [31:0] ticks, input logic [7:0] pulses);
    logic [31:0] readback;
    reg_write(ADDR_TICKS, ticks);
    reg_write(ADDR_PULSES, {24'd0, pulses});
    reg_read(ADDR_TICKS, readback);
    if (readback !== ticks) begin
      speeds.flag($sformatf("ticks_per_minute reads %0h, expected %0h", readback, ticks));
    end
    reg_read(ADDR_PULSES, readback);
    if (readback !== {24'd0, pulses}) begin
      speeds.flag($sformatf("edges_per_rev reads %0h, expected %0h", readback, pulses));
    end
    speeds.set_rates(ticks, pulses);
  endtask

  // Main sequence.
  initial begin
    logic [31:0] phase_ticks [RANDOM_PHASES];
    logic [7:0]  phase_pulses [RANDOM_PHASES];

    // Rate settings for the random phases: the reset values, both extremes,
    // the largest numerator over one pulse, a zero pulse count and random mixes.
    phase_ticks = '{32'd60000000, 32'hFFFF_FFFF, 32'd1, $urandom, 32'hFFFF_FFFF,
                    $urandom, 32'd60000000};
    phase_pulses = '{8'd28, 8'd255, 8'd1, 8'($urandom_range(1, 255)), 8'd1, 8'd0,
                     8'($urandom_range(1, 255))};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, first under the reset values of the rate registers.
    // A first capture at the reset timestamp gives a zero period and so a
    // zero average. Then a full-range period, and a period of one across the
    // timer wrap.
    gaps_on = 1'b0;
    send_capture(cap_of(1'b0, 16'h0000));
    send_capture(cap_of(1'b0, 16'hFFFF));
    send_capture(cap_of(1'b0, 16'h0000));
    // Channel 1: a first capture, then repeated timestamps keep the sum at
    // zero so the averaged result is zero as well, and a period of one that
    // still averages down to zero.
    send_capture(cap_of(1'b1, 16'h1234));
    send_capture(cap_of(1'b1, 16'h1234));
    send_capture(cap_of(1'b1, 16'h1234));
    send_capture(cap_of(1'b1, 16'h1235));
    send_capture(cap_of(1'b0, 16'h8000));
    send_capture(cap_of(1'b1, 16'h9235));
    wait_idle();

    // Largest numerator and pulse count.
    set_rates(32'hFFFF_FFFF, 8'd255);
    send_capture(cap_of(1'b0, 16'h8001));
    send_capture(cap_of(1'b1, 16'hFFFF));
    send_capture(cap_of(1'b0, 16'h7FFF));
    wait_idle();

    // Smallest numerator and pulse count: speed is 1 only at an average of 1.
    set_rates(32'd1, 8'd1);
    send_capture(cap_of(1'b1, 16'h0000));
    send_capture(cap_of(1'b0, 16'h8000));
    send_capture(cap_of(1'b0, 16'h8001));
    wait_idle();

    // Zero pulses per revolution: the divisor is zero and the speed is zero,
    // while the zero flag still follows the average alone.
    set_rates(32'd60000000, 8'd0);
    send_capture(cap_of(1'b0, 16'h8001));
    send_capture(cap_of(1'b1, 16'h0100));
    send_capture(cap_of(1'b0, 16'hC000));
    wait_idle();

    // Random phases. Each starts from an idle block with new rates; every
    // third phase runs without sender gaps. In the third phase the receiver
    // is told to hold off for a long stretch while captures keep coming, so
    // the output register fills and the block stalls its input.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_rates(phase_ticks[p], phase_pulses[p]);
      gaps_on = (p % 3) != 0;
      for (int n = 0; n < CAPTURES_PER_PHASE; n++) begin
        if (p == 2 && n == 50) begin
          hold_requests <= hold_requests + 1;
        end
        send_capture(next_capture());
      end
      // The sender pauses here until every result of the phase is back.
      wait_idle();
    end

    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (speeds.failures == 0 && speeds.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
